>>> rtl/tcw_pkg.sv
// Shared types and constants of the text console window block.
package tcw_pkg;

	// Widths of the on-screen coordinates formed from window origin plus offset.
	localparam int CROW_W = 7;
	localparam int CCOL_W = 7;
	localparam int PROD_W = CROW_W + CCOL_W;

	// Configuration port.
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam logic [2:0] REG_WINDOW_LEFT   = 3'd0;
	localparam logic [2:0] REG_WINDOW_TOP    = 3'd1;
	localparam logic [2:0] REG_WINDOW_WIDTH  = 3'd2;
	localparam logic [2:0] REG_WINDOW_HEIGHT = 3'd3;
	localparam logic [2:0] REG_INK_ATTR      = 3'd4;
	localparam logic [2:0] REG_PAPER_ATTR    = 3'd5;

	// Input actions.
	localparam logic [1:0] ACT_PUT   = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;
	localparam logic [1:0] ACT_NONE  = 2'd3;

	// Classified commands passed from the front end to the back end.
	localparam logic [2:0] CMD_PUT     = 3'd0;
	localparam logic [2:0] CMD_NEWLINE = 3'd1;
	localparam logic [2:0] CMD_READ    = 3'd2;
	localparam logic [2:0] CMD_CLEAR   = 3'd3;
	localparam logic [2:0] CMD_NOP     = 3'd4;

	localparam logic [7:0] SPACE_CODE   = 8'h20;
	localparam logic [7:0] NEWLINE_CODE = 8'h0A;

	typedef struct packed {
		logic [5:0] left;
		logic [4:0] top;
		logic [5:0] width;
		logic [4:0] height;
		logic [2:0] ink;
		logic [4:0] paper;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		left:   6'd2,
		top:    5'd0,
		width:  6'd38,
		height: 5'd28,
		ink:    3'd7,
		paper:  5'd16
	};

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] ch;
		logic [4:0] row;
		logic [5:0] col;
	} cmd_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [5:0] cursor_col;
		logic [4:0] cursor_row;
		logic       scrolled;
	} res_t;

endpackage

>>> rtl/text_console_window_core.sv
// Top level of the text console window: configuration registers and result queue.
// Each command passes the front-end stage and command queue, then the back-end
// sequencer, whose done state pushes its result into the result queue; a scroll
// copies the window up and blanks its bottom row, and a clear blanks every window row.
// The sequencer makes at most one screen memory access per cycle and takes a new
// command only when idle. Reset clears the cursor, queues and registers;
// screen memory is not cleared and holds no defined value until written.
module text_console_window_core
	import tcw_pkg::*;
#(
	parameter int SCREEN_ROWS_P  = 28,
	parameter int SCREEN_COLUMNS = 40
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration port.
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	// Input items.
	input  logic                  push,
	output logic                  full,
	input  logic [1:0]            action,
	input  logic [7:0]            char_code,
	input  logic [4:0]            cell_row,
	input  logic [5:0]            cell_col,
	// Result items.
	output logic                  empty,
	input  logic                  pop,
	output logic [7:0]            read_data,
	output logic [5:0]            cursor_col,
	output logic [4:0]            cursor_row,
	output logic                  scrolled
);

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       cfg_wr;
	logic       cmd_valid;
	cmd_t       cmd;
	logic       cmd_pop;
	logic       res_full;
	logic       res_push;
	res_t       res_in;
	logic [$bits(res_t)-1:0] res_rdata;
	res_t       res_out;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_WINDOW_LEFT:   cfg_q.left   <= pwdata[5:0];
				REG_WINDOW_TOP:    cfg_q.top    <= pwdata[4:0];
				REG_WINDOW_WIDTH:  cfg_q.width  <= pwdata[5:0];
				REG_WINDOW_HEIGHT: cfg_q.height <= pwdata[4:0];
				REG_INK_ATTR:      cfg_q.ink    <= pwdata[2:0];
				REG_PAPER_ATTR:    cfg_q.paper  <= pwdata[4:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WINDOW_LEFT:   prdata = APB_DATA_W'(cfg_q.left);
			REG_WINDOW_TOP:    prdata = APB_DATA_W'(cfg_q.top);
			REG_WINDOW_WIDTH:  prdata = APB_DATA_W'(cfg_q.width);
			REG_WINDOW_HEIGHT: prdata = APB_DATA_W'(cfg_q.height);
			REG_INK_ATTR:      prdata = APB_DATA_W'(cfg_q.ink);
			REG_PAPER_ATTR:    prdata = APB_DATA_W'(cfg_q.paper);
			default:           prdata = '0;
		endcase
	end

	tcw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.action    (action),
		.char_code (char_code),
		.cell_row  (cell_row),
		.cell_col  (cell_col),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	tcw_back #(
		.SCREEN_ROWS_P  (SCREEN_ROWS_P),
		.SCREEN_COLUMNS (SCREEN_COLUMNS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	// Finished results wait here so the sequencer can move on while pop is low.
	tcw_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign res_out    = res_t'(res_rdata);
	assign read_data  = res_out.read_data;
	assign cursor_col = res_out.cursor_col;
	assign cursor_row = res_out.cursor_row;
	assign scrolled   = res_out.scrolled;

endmodule

>>> rtl/tcw_ram.sv
// Generic single-port RAM, one address shared by write and read, with registered read data.
module tcw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1120
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/tcw_fifo.sv
// Small first-in first-out queue with full and empty flags.
module tcw_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue holds more entries than its depth");

	a_count_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && !(pop && !empty)) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not grow on a lone push");

endmodule

>>> rtl/tcw_front.sv
// Front end: accepts input items, classifies them and queues commands.
module tcw_front
	import tcw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] action,
	input  logic [7:0] char_code,
	input  logic [4:0] cell_row,
	input  logic [5:0] cell_col,
	output logic       cmd_valid,
	output cmd_t       cmd,
	input  logic       cmd_pop
);

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_in;
	logic q_full;
	logic q_empty;
	logic advance;

	always_comb begin
		cmd_in     = '0;
		cmd_in.ch  = char_code;
		cmd_in.row = cell_row;
		cmd_in.col = cell_col;
		unique case (action)
			ACT_PUT:   cmd_in.kind = (char_code == NEWLINE_CODE) ? CMD_NEWLINE : CMD_PUT;
			ACT_READ:  cmd_in.kind = CMD_READ;
			ACT_CLEAR: cmd_in.kind = CMD_CLEAR;
			default:   cmd_in.kind = CMD_NOP;
		endcase
	end

	// The stage moves on whenever it is empty or its command enters the queue.
	assign advance = !valid_s1 || !q_full;
	assign full    = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && push) begin
			cmd_s1 <= cmd_in;
		end
	end

	logic [$bits(cmd_t)-1:0] q_rdata;

	tcw_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (2)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (valid_s1),
		.wdata  (cmd_s1),
		.full   (q_full),
		.pop    (cmd_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	assign cmd_valid = !q_empty;
	assign cmd       = cmd_t'(q_rdata);

endmodule

>>> rtl/tcw_back.sv
// Back end: sequencer that carries out commands on the screen memory.
module tcw_back
	import tcw_pkg::*;
#(
	parameter int SCREEN_ROWS_P  = 28,
	parameter int SCREEN_COLUMNS = 40
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	input  logic res_full,
	output logic res_push,
	output res_t res
);

	localparam int DEPTH = SCREEN_ROWS_P * SCREEN_COLUMNS;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [7:0] ROWS_L = 8'(SCREEN_ROWS_P);
	localparam logic [7:0] COLS_L = 8'(SCREEN_COLUMNS);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_PUT    = 4'd1;
	localparam logic [3:0] ST_NEXT   = 4'd2;
	localparam logic [3:0] ST_BATTR0 = 4'd3;
	localparam logic [3:0] ST_BATTR1 = 4'd4;
	localparam logic [3:0] ST_BSPC   = 4'd5;
	localparam logic [3:0] ST_SCRD   = 4'd6;
	localparam logic [3:0] ST_SCWR   = 4'd7;
	localparam logic [3:0] ST_READ   = 4'd8;
	localparam logic [3:0] ST_RWAIT  = 4'd9;
	localparam logic [3:0] ST_DONE   = 4'd10;

	logic [3:0]  state_q;
	logic [5:0]  cur_col_q;
	logic [4:0]  cur_line_q;
	logic [4:0]  y_q;
	logic [5:0]  x_q;
	logic        attr_only_q;
	logic        scr_q;
	logic [7:0]  rd_q;
	logic        src_in_q;
	cmd_t        cmd_q;

	logic [5:0]        eff_w;
	logic [4:0]        eff_h;
	logic [CROW_W-1:0] row_sel;
	logic [CCOL_W-1:0] col_sel;
	logic [7:0]        wdata;
	logic              we_raw;
	logic              re_raw;
	logic              in_screen;
	logic [PROD_W-1:0] addr_full;
	logic [AW-1:0]     ram_addr;
	logic [7:0]        ram_rdata;
	logic              x_last;
	logic              y_last;

	assign eff_w  = (cfg.width == '0) ? 6'd1 : cfg.width;
	assign eff_h  = (cfg.height == '0) ? 5'd1 : cfg.height;
	assign x_last = !(({1'b0, x_q} + 7'd1) < {1'b0, eff_w});
	assign y_last = !(({1'b0, y_q} + 6'd1) < {1'b0, eff_h});

	// Cell addressing for the current step of the sequencer.
	always_comb begin
		row_sel = '0;
		col_sel = '0;
		wdata   = '0;
		we_raw  = 1'b0;
		re_raw  = 1'b0;
		unique case (state_q)
			ST_PUT: begin
				row_sel = CROW_W'(cfg.top) + CROW_W'(cur_line_q);
				col_sel = CCOL_W'(cfg.left) + CCOL_W'(cur_col_q);
				wdata   = cmd_q.ch;
				we_raw  = 1'b1;
			end
			ST_BATTR0: begin
				row_sel = CROW_W'(cfg.top) + CROW_W'(y_q);
				col_sel = CCOL_W'(0);
				wdata   = 8'(cfg.ink);
				we_raw  = 1'b1;
			end
			ST_BATTR1: begin
				row_sel = CROW_W'(cfg.top) + CROW_W'(y_q);
				col_sel = CCOL_W'(1);
				wdata   = 8'(cfg.paper);
				we_raw  = 1'b1;
			end
			ST_BSPC: begin
				row_sel = CROW_W'(cfg.top) + CROW_W'(y_q);
				col_sel = CCOL_W'(cfg.left) + CCOL_W'(x_q);
				wdata   = SPACE_CODE;
				we_raw  = 1'b1;
			end
			ST_SCRD: begin
				row_sel = CROW_W'(cfg.top) + CROW_W'(y_q) + CROW_W'(1);
				col_sel = CCOL_W'(cfg.left) + CCOL_W'(x_q);
				re_raw  = 1'b1;
			end
			ST_SCWR: begin
				row_sel = CROW_W'(cfg.top) + CROW_W'(y_q);
				col_sel = CCOL_W'(cfg.left) + CCOL_W'(x_q);
				wdata   = src_in_q ? ram_rdata : 8'd0;
				we_raw  = 1'b1;
			end
			ST_READ: begin
				row_sel = CROW_W'(cmd_q.row);
				col_sel = CCOL_W'(cmd_q.col);
				re_raw  = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign in_screen = ({1'b0, row_sel} < ROWS_L) && ({1'b0, col_sel} < COLS_L);
	assign addr_full = PROD_W'(row_sel) * PROD_W'(SCREEN_COLUMNS) + PROD_W'(col_sel);
	assign ram_addr  = addr_full[AW-1:0];

	tcw_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_screen (
		.clk   (clk),
		.we    (we_raw & in_screen),
		.re    (re_raw & in_screen),
		.addr  (ram_addr),
		.wdata (wdata),
		.rdata (ram_rdata)
	);

	assign cmd_pop  = (state_q == ST_IDLE) && cmd_valid;
	assign res_push = (state_q == ST_DONE) && !res_full;
	assign res      = '{read_data: rd_q, cursor_col: cur_col_q,
		cursor_row: cur_line_q, scrolled: scr_q};

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if ((state_q == ST_SCRD) || (state_q == ST_READ)) begin
			src_in_q <= in_screen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_col_q   <= '0;
			cur_line_q  <= '0;
			y_q         <= '0;
			x_q         <= '0;
			attr_only_q <= 1'b0;
			scr_q       <= 1'b0;
			rd_q        <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						scr_q <= 1'b0;
						rd_q  <= '0;
						unique case (cmd.kind)
							CMD_PUT:     state_q <= ST_PUT;
							CMD_NEWLINE: state_q <= ST_NEXT;
							CMD_READ:    state_q <= ST_READ;
							CMD_CLEAR: begin
								cur_col_q   <= '0;
								cur_line_q  <= '0;
								y_q         <= '0;
								attr_only_q <= 1'b0;
								state_q     <= ST_BATTR0;
							end
							default:     state_q <= ST_DONE;
						endcase
					end
				end
				ST_PUT: begin
					if (({1'b0, cur_col_q} + 7'd1) >= {1'b0, eff_w}) begin
						state_q <= ST_NEXT;
					end else begin
						cur_col_q <= cur_col_q + 6'd1;
						state_q   <= ST_DONE;
					end
				end
				ST_NEXT: begin
					cur_col_q <= '0;
					if (({1'b0, cur_line_q} + 6'd1) < {1'b0, eff_h}) begin
						cur_line_q  <= cur_line_q + 5'd1;
						y_q         <= cur_line_q + 5'd1;
						attr_only_q <= 1'b1;
						state_q     <= ST_BATTR0;
					end else begin
						scr_q       <= 1'b1;
						x_q         <= '0;
						attr_only_q <= 1'b0;
						if (eff_h > 5'd1) begin
							y_q     <= '0;
							state_q <= ST_SCRD;
						end else begin
							y_q     <= eff_h - 5'd1;
							state_q <= ST_BATTR0;
						end
					end
				end
				ST_SCRD: begin
					state_q <= ST_SCWR;
				end
				ST_SCWR: begin
					if (!x_last) begin
						x_q     <= x_q + 6'd1;
						state_q <= ST_SCRD;
					end else begin
						x_q <= '0;
						if (({1'b0, y_q} + 6'd2) < {1'b0, eff_h}) begin
							y_q     <= y_q + 5'd1;
							state_q <= ST_SCRD;
						end else begin
							// Copy done; the bottom row is blanked next.
							y_q     <= eff_h - 5'd1;
							state_q <= ST_BATTR0;
						end
					end
				end
				ST_BATTR0: begin
					state_q <= ST_BATTR1;
				end
				ST_BATTR1: begin
					x_q     <= '0;
					state_q <= attr_only_q ? ST_DONE : ST_BSPC;
				end
				ST_BSPC: begin
					if (!x_last) begin
						x_q <= x_q + 6'd1;
					end else if (!y_last) begin
						x_q     <= '0;
						y_q     <= y_q + 5'd1;
						state_q <= ST_BATTR0;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_READ: begin
					state_q <= ST_RWAIT;
				end
				ST_RWAIT: begin
					rd_q    <= src_in_q ? ram_rdata : 8'd0;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_copy_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCWR) |-> ($past(state_q) == ST_SCRD))
		else $error("scroll write step without a preceding read step");

	a_scroll_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(scr_q) |-> ($past(state_q) == ST_NEXT))
		else $error("scroll flag raised outside the new-row step");

	a_cursor_hold: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCWR) || (state_q == ST_BSPC))
			|-> ($stable(cur_line_q) && $stable(cur_col_q)))
		else $error("cursor moved during a window copy or blanking pass");

endmodule

>>> tb/tb_text_console_window_core.sv
// Self-checking testbench of the text console window core.
`timescale 1ns / 100ps

module tb_text_console_window_core;
	import tcw_pkg::*;

	localparam int ROWS = 28;
	localparam int COLS = 40;
	localparam int RAND_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 240;
	localparam logic [2:0] REG_ORDER [6] = '{REG_WINDOW_LEFT, REG_WINDOW_TOP,
		REG_WINDOW_WIDTH, REG_WINDOW_HEIGHT, REG_INK_ATTR, REG_PAPER_ATTR};

	typedef struct {
		logic [1:0] action;
		logic [7:0] ch;
		logic [4:0] row;
		logic [5:0] col;
	} console_req_t;

	logic clk;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;
	logic push = 1'b0;
	logic full;
	logic [1:0] action = ACT_NONE;
	logic [7:0] char_code = '0;
	logic [4:0] cell_row = '0;
	logic [5:0] cell_col = '0;
	logic empty;
	logic pop = 1'b0;
	logic [7:0] read_data;
	logic [5:0] cursor_col;
	logic [4:0] cursor_row;
	logic scrolled;

	text_console_window_core #(
		.SCREEN_ROWS_P(ROWS),
		.SCREEN_COLUMNS(COLS)
	) DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.push(push), .full(full), .action(action), .char_code(char_code),
		.cell_row(cell_row), .cell_col(cell_col),
		.empty(empty), .pop(pop), .read_data(read_data), .cursor_col(cursor_col),
		.cursor_row(cursor_row), .scrolled(scrolled)
	);

	// Predicted block state.
	logic [7:0] screen_img [ROWS*COLS];
	bit readable [ROWS*COLS];
	int unsigned cur_col = 0;
	int unsigned cur_line = 0;
	cfg_t win = CFG_RESET;

	console_req_t queued_reqs [$];
	res_t awaited_results [$];
	res_t want;
	console_req_t next_req;

	int fail_count = 0;
	int results_seen = 0;
	int scrolls_seen = 0;
	int puts_done = 0;
	int reads_done = 0;
	int clears_done = 0;
	int nops_done = 0;
	int settings_used = 0;
	int send_gap = 0;
	int recv_gap = 0;
	bit calm = 1'b0;
	bit hold_results = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#400ms;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int unsigned span_w();
		return (win.width == 0) ? 1 : win.width;
	endfunction

	function automatic int unsigned span_h();
		return (win.height == 0) ? 1 : win.height;
	endfunction

	function automatic void cell_put(int unsigned r, int unsigned c, logic [7:0] v);
		if (r < ROWS && c < COLS)
			screen_img[r*COLS + c] = v;
	endfunction

	function automatic logic [7:0] cell_get(int unsigned r, int unsigned c);
		if (r < ROWS && c < COLS)
			return screen_img[r*COLS + c];
		return 8'h00;
	endfunction

	function automatic void stamp_attrs(int unsigned r);
		cell_put(r, 0, {5'b0, win.ink});
		cell_put(r, 1, {3'b0, win.paper});
	endfunction

	function automatic void blank_line(int unsigned r);
		stamp_attrs(r);
		for (int unsigned x = 0; x < span_w(); x++)
			cell_put(r, win.left + x, SPACE_CODE);
	endfunction

	function automatic void scroll_up();
		for (int unsigned y = 0; y + 1 < span_h(); y++)
			for (int unsigned x = 0; x < span_w(); x++)
				cell_put(win.top + y, win.left + x, cell_get(win.top + y + 1, win.left + x));
		blank_line(win.top + span_h() - 1);
	endfunction

	// Returns 1 when the window had to scroll to make room for the new row.
	function automatic bit advance_line();
		cur_col = 0;
		if (cur_line + 1 < span_h()) begin
			cur_line++;
			stamp_attrs(win.top + cur_line);
			return 1'b0;
		end
		scroll_up();
		return 1'b1;
	endfunction

	function automatic res_t console_step(console_req_t rq);
		res_t r;
		r = '0;
		case (rq.action)
			ACT_PUT: begin
				puts_done++;
				if (rq.ch == NEWLINE_CODE) begin
					r.scrolled = advance_line();
				end else begin
					cell_put(win.top + cur_line, win.left + cur_col, rq.ch);
					if (cur_col + 1 >= span_w())
						r.scrolled = advance_line();
					else
						cur_col++;
				end
			end
			ACT_READ: begin
				reads_done++;
				r.read_data = cell_get(rq.row, rq.col);
			end
			ACT_CLEAR: begin
				clears_done++;
				for (int unsigned y = 0; y < span_h(); y++)
					blank_line(win.top + y);
				cur_col = 0;
				cur_line = 0;
			end
			default: nops_done++;
		endcase
		r.cursor_col = cur_col[5:0];
		r.cursor_row = cur_line[4:0];
		return r;
	endfunction

	function automatic logic [31:0] reg_expect(logic [2:0] idx);
		case (idx)
			REG_WINDOW_LEFT:   return 32'(win.left);
			REG_WINDOW_TOP:    return 32'(win.top);
			REG_WINDOW_WIDTH:  return 32'(win.width);
			REG_WINDOW_HEIGHT: return 32'(win.height);
			REG_INK_ATTR:      return 32'(win.ink);
			REG_PAPER_ATTR:    return 32'(win.paper);
			default:           return 32'h0;
		endcase
	endfunction

	function automatic void note_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
		end
	endfunction

	// Input side: the expectation is formed at the edge of each accepted transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			action <= ACT_NONE;
			char_code <= '0;
			cell_row <= '0;
			cell_col <= '0;
		end else begin
			if (push && !full)
				awaited_results.push_back(console_step('{action, char_code, cell_row, cell_col}));
			if (!push || !full) begin
				if (send_gap != 0) begin
					push <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (queued_reqs.size() != 0) begin
					next_req = queued_reqs.pop_front();
					action <= next_req.action;
					char_code <= next_req.ch;
					cell_row <= next_req.row;
					cell_col <= next_req.col;
					push <= 1'b1;
					if (!calm && $urandom_range(0, 7) == 0)
						send_gap <= $urandom_range(1, 6);
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Result side.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				results_seen++;
				if (scrolled)
					scrolls_seen++;
				if (awaited_results.size() == 0) begin
					fail_count++;
					$display("%0t: result with none expected, expected none, actual %0h/%0h/%0h/%0h",
						$time, read_data, cursor_col, cursor_row, scrolled);
				end else begin
					want = awaited_results.pop_front();
					note_field("read_data", want.read_data, read_data);
					note_field("cursor_col", want.cursor_col, cursor_col);
					note_field("cursor_row", want.cursor_row, cursor_row);
					note_field("scrolled", want.scrolled, scrolled);
				end
			end
			if (hold_results || recv_gap != 0) begin
				pop <= 1'b0;
				if (recv_gap != 0)
					recv_gap <= recv_gap - 1;
			end else begin
				pop <= 1'b1;
				if (!calm && $urandom_range(0, 7) == 0)
					recv_gap <= $urandom_range(1, 6);
			end
		end
	end

	// One long hold-off on the result side so that the block fills and stalls its input.
	initial begin
		wait (results_seen >= 150);
		@(posedge clk);
		hold_results <= 1'b1;
		repeat (400) @(posedge clk);
		hold_results <= 1'b0;
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_WINDOW_LEFT:   win.left = value[5:0];
			REG_WINDOW_TOP:    win.top = value[4:0];
			REG_WINDOW_WIDTH:  win.width = value[5:0];
			REG_WINDOW_HEIGHT: win.height = value[4:0];
			REG_INK_ATTR:      win.ink = value[2:0];
			REG_PAPER_ATTR:    win.paper = value[4:0];
			default: ;
		endcase
	endtask

	task automatic check_regs();
		logic [31:0] got;
		foreach (REG_ORDER[i]) begin
			@(posedge clk);
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b0;
			paddr <= {REG_ORDER[i], 2'b00};
			@(posedge clk);
			penable <= 1'b1;
			// Sampled mid-cycle of the access phase, away from the clock edge.
			@(negedge clk);
			got = prdata;
			@(posedge clk);
			psel <= 1'b0;
			penable <= 1'b0;
			note_field("register readback", reg_expect(REG_ORDER[i]), got);
		end
	endtask

	task automatic set_window(input int lf, input int tp, input int wd, input int ht,
		input int ink, input int paper);
		write_reg(REG_WINDOW_LEFT, lf);
		write_reg(REG_WINDOW_TOP, tp);
		write_reg(REG_WINDOW_WIDTH, wd);
		write_reg(REG_WINDOW_HEIGHT, ht);
		write_reg(REG_INK_ATTR, ink);
		write_reg(REG_PAPER_ATTR, paper);
		check_regs();
		settings_used++;
	endtask

	// Waits until the block has nothing in flight.
	task automatic settle();
		while (!(queued_reqs.size() == 0 && !push && awaited_results.size() == 0))
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic queue_req(input logic [1:0] act, input logic [7:0] ch, input int r, input int c);
		queued_reqs.push_back('{act, ch, r[4:0], c[5:0]});
	endtask

	task automatic queue_put(input logic [7:0] ch);
		queue_req(ACT_PUT, ch, $urandom_range(0, 31), $urandom_range(0, 63));
	endtask

	// A clear leaves every on-screen cell of the window written, so those become safe to read.
	task automatic queue_clear();
		int unsigned r, c;
		queue_req(ACT_CLEAR, 8'($urandom_range(0, 255)), $urandom_range(0, 31),
			$urandom_range(0, 63));
		for (int unsigned y = 0; y < span_h(); y++) begin
			r = win.top + y;
			if (r < ROWS) begin
				readable[r*COLS] = 1'b1;
				readable[r*COLS + 1] = 1'b1;
				for (int unsigned x = 0; x < span_w(); x++) begin
					c = win.left + x;
					if (c < COLS)
						readable[r*COLS + c] = 1'b1;
				end
			end
		end
	endtask

	// Reads only cells known to be written by then, or cells off the screen.
	task automatic queue_random_read();
		int unsigned r, c;
		bit found;
		found = 1'b0;
		if ($urandom_range(0, 9) != 0) begin
			r = win.top + $urandom_range(0, span_h() - 1);
			c = win.left + $urandom_range(0, span_w() - 1);
			found = (r < ROWS && c < COLS) && readable[r*COLS + c];
			for (int tries = 0; tries < 12 && !found; tries++) begin
				r = $urandom_range(0, ROWS - 1);
				c = $urandom_range(0, COLS - 1);
				found = readable[r*COLS + c];
			end
		end
		if (!found) begin
			if ($urandom_range(0, 1)) begin
				r = $urandom_range(ROWS, 31);
				c = $urandom_range(0, 63);
			end else begin
				r = $urandom_range(0, 31);
				c = $urandom_range(COLS, 63);
			end
		end
		queue_req(ACT_READ, 8'($urandom_range(0, 255)), r, c);
	endtask

	task automatic queue_random(input int nl_pct);
		int k;
		k = $urandom_range(0, 99);
		if (k < nl_pct)
			queue_put(NEWLINE_CODE);
		else if (k < 65)
			queue_put(8'($urandom_range(0, 1) ? $urandom_range(0, 255) :
				$urandom_range(8'h20, 8'h7E)));
		else if (k < 90)
			queue_random_read();
		else if (k < 93)
			queue_clear();
		else
			queue_req(ACT_NONE, 8'($urandom_range(0, 255)), $urandom_range(0, 31),
				$urandom_range(0, 63));
	endtask

	initial begin
		int lf, tp, wd, ht, nl;
		foreach (screen_img[i])
			screen_img[i] = 8'h00;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		check_regs();

		// Reset window: bytes at both ends of the range, a new row, reads on and off the screen.
		queue_clear();
		queue_put(8'h00);
		queue_put(8'hFF);
		queue_put(NEWLINE_CODE);
		queue_req(ACT_READ, 8'h00, 0, 2);
		queue_req(ACT_READ, 8'h00, 1, 0);
		queue_req(ACT_READ, 8'hFF, 31, 63);
		queue_req(ACT_NONE, 8'hFF, 31, 63);
		settle();

		// Window reaching past the right and bottom edges of the screen.
		set_window(39, 27, 38, 28, 7, 23);
		queue_clear();
		queue_put("Z");
		queue_put(NEWLINE_CODE);
		queue_req(ACT_READ, 8'h00, 27, 39);
		settle();

		// Zero width and height act as one, so every character scrolls.
		set_window(0, 0, 0, 0, 0, 0);
		queue_clear();
		queue_put("a");
		queue_put(NEWLINE_CODE);
		queue_req(ACT_READ, 8'h00, 0, 0);
		settle();

		// Cursor left beyond the window after it shrinks.
		set_window(2, 0, 10, 6, 5, 17);
		queue_clear();
		repeat (4) queue_put(NEWLINE_CODE);
		queue_put("p");
		queue_put("q");
		queue_put("r");
		settle();
		set_window(2, 0, 3, 2, 5, 17);
		queue_put("X");
		queue_req(ACT_READ, 8'h00, 4, 5);

		for (int p = 0; p < RAND_PHASES; p++) begin
			settle();
			nl = 12;
			if (p == 1) begin
				lf = 2; tp = 0; wd = 38; ht = 28;
				nl = 30;
			end else if (p == 4) begin
				lf = 39; tp = 27; wd = 38; ht = 28;
			end else begin
				lf = ($urandom_range(0, 4) != 0) ? $urandom_range(2, 39) : $urandom_range(0, 63);
				tp = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 27) : $urandom_range(0, 31);
				wd = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 12) : $urandom_range(0, 63);
				ht = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 8) : $urandom_range(0, 31);
			end
			if (p == RAND_PHASES - 1)
				calm = 1'b1;
			set_window(lf, tp, wd, ht, $urandom_range(0, 7),
				($urandom_range(0, 9) < 7) ? $urandom_range(16, 23) : $urandom_range(0, 31));
			queue_clear();
			repeat (ITEMS_PER_PHASE) queue_random(nl);
		end

		settle();
		// Room for the longest scroll to show any stray result.
		repeat (4500) @(posedge clk);
		$display("Covered %0d character puts, %0d cell reads, %0d clears, %0d unused actions",
			puts_done, reads_done, clears_done, nops_done);
		$display("over %0d window settings; %0d results checked, %0d of them scrolls",
			settings_used, results_seen, scrolls_seen);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
